>>> src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the message frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int HDR_BYTES   = 12;
    localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int PADDR_W     = 4;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_EMPTY = 2'd1,
        ACT_LINK  = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_TOO_BIG   = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_LINK_DOWN = 3'd4,
        ST_STOPPED   = 3'd5
    } status_t;

    localparam logic [1:0] REG_MAGIC    = 2'd0;
    localparam logic [1:0] REG_VERSION  = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;
    localparam logic [1:0] REG_IDLE     = 2'd3;

    typedef struct packed {
        logic [15:0] magic_word;
        logic [7:0]  wire_version;
        logic [31:0] payload_capacity;
        logic [31:0] idle_limit;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        frame_done;
        logic [7:0]  msg_type;
        logic [15:0] seq_number;
        logic [15:0] channel_id;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        payload_valid;
    } result_t;

endpackage

>>> src/mfd_front.sv
// ----------------------------------------------------------------------------
// mfd_front
// Event classifier: header collection, checks, payload count, idle timeout.
// ----------------------------------------------------------------------------
module mfd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [1:0]           action,
    input  logic [7:0]           data_byte,
    input  mfd_pkg::cfg_t        cfg,
    output logic                 push,
    output mfd_pkg::result_t     result
);

    logic [7:0]                   hdr_reg [mfd_pkg::HDR_BYTES];
    logic [mfd_pkg::HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic                         in_payload_reg, in_payload_next;
    logic [31:0]                  left_reg, left_next;
    logic [31:0]                  idle_reg, idle_next;
    logic [7:0]                   fld_type_reg, fld_type_next;
    logic [15:0]                  fld_seq_reg, fld_seq_next;
    logic [15:0]                  fld_chan_reg, fld_chan_next;
    logic [31:0]                  fld_len_reg, fld_len_next;
    logic                         hdr_we;

    logic [15:0] hdr_magic;
    logic [7:0]  hdr_version;
    logic [31:0] hdr_len;
    logic [31:0] idle_inc;
    logic [31:0] left_dec;
    mfd_pkg::action_t act;

    assign act         = mfd_pkg::action_t'(action);
    assign hdr_magic   = {hdr_reg[1], hdr_reg[0]};
    assign hdr_version = hdr_reg[2];
    assign hdr_len     = {data_byte, hdr_reg[10], hdr_reg[9], hdr_reg[8]};
    assign idle_inc    = (idle_reg == 32'hFFFF_FFFF) ? idle_reg : idle_reg + 32'd1;
    assign left_dec    = left_reg - 32'd1;

    always_comb begin
        hdr_idx_next    = hdr_idx_reg;
        in_payload_next = in_payload_reg;
        left_next       = left_reg;
        idle_next       = idle_reg;
        fld_type_next   = fld_type_reg;
        fld_seq_next    = fld_seq_reg;
        fld_chan_next   = fld_chan_reg;
        fld_len_next    = fld_len_reg;
        hdr_we          = 1'b0;
        push            = 1'b0;
        result          = '0;
        result.status   = mfd_pkg::ST_OK;
        if (in_payload_reg) begin
            result.msg_type       = fld_type_reg;
            result.seq_number     = fld_seq_reg;
            result.channel_id     = fld_chan_reg;
            result.payload_length = fld_len_reg;
        end
        if (in_fire) begin
            case (act)
                mfd_pkg::ACT_STOP, mfd_pkg::ACT_LINK: begin
                    push              = 1'b1;
                    result.status     = (act == mfd_pkg::ACT_STOP) ? mfd_pkg::ST_STOPPED
                                                                   : mfd_pkg::ST_LINK_DOWN;
                    result.frame_done = 1'b1;
                end
                mfd_pkg::ACT_EMPTY: begin
                    idle_next = idle_inc;
                    if (cfg.idle_limit != 32'd0 && idle_inc >= cfg.idle_limit) begin
                        push              = 1'b1;
                        result.status     = mfd_pkg::ST_TIMEOUT;
                        result.frame_done = 1'b1;
                    end
                end
                mfd_pkg::ACT_BYTE: begin
                    idle_next = '0;
                    if (in_payload_reg) begin
                        left_next            = left_dec;
                        push                 = 1'b1;
                        result.payload_byte  = data_byte;
                        result.payload_valid = 1'b1;
                        result.frame_done    = (left_dec == 32'd0);
                    end else begin
                        hdr_we = 1'b1;
                        if (hdr_idx_reg == mfd_pkg::HDR_LAST) begin
                            hdr_idx_next  = '0;
                            push          = 1'b1;
                            fld_type_next = hdr_reg[3];
                            fld_seq_next  = {hdr_reg[5], hdr_reg[4]};
                            fld_chan_next = {hdr_reg[7], hdr_reg[6]};
                            fld_len_next  = hdr_len;
                            if (hdr_magic != cfg.magic_word ||
                                hdr_version != cfg.wire_version) begin
                                result.status     = mfd_pkg::ST_BAD_HDR;
                                result.frame_done = 1'b1;
                            end else begin
                                result.msg_type       = fld_type_next;
                                result.seq_number     = fld_seq_next;
                                result.channel_id     = fld_chan_next;
                                result.payload_length = hdr_len;
                                if (hdr_len > cfg.payload_capacity) begin
                                    result.status     = mfd_pkg::ST_TOO_BIG;
                                    result.frame_done = 1'b1;
                                end else if (hdr_len == 32'd0) begin
                                    result.frame_done = 1'b1;
                                end else begin
                                    in_payload_next = 1'b1;
                                    left_next       = hdr_len;
                                end
                            end
                        end else begin
                            hdr_idx_next = hdr_idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (push && result.frame_done) begin
                hdr_idx_next    = '0;
                in_payload_next = 1'b0;
                left_next       = '0;
                idle_next       = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_idx_reg    <= '0;
            in_payload_reg <= 1'b0;
            left_reg       <= '0;
            idle_reg       <= '0;
        end else begin
            hdr_idx_reg    <= hdr_idx_next;
            in_payload_reg <= in_payload_next;
            left_reg       <= left_next;
            idle_reg       <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        fld_type_reg <= fld_type_next;
        fld_seq_reg  <= fld_seq_next;
        fld_chan_reg <= fld_chan_next;
        fld_len_reg  <= fld_len_next;
        if (hdr_we) begin
            hdr_reg[hdr_idx_reg] <= data_byte;
        end
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_idx_reg <= mfd_pkg::HDR_LAST)
        else $error("header index out of range");

    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (left_reg != 32'd0 && hdr_idx_reg == '0))
        else $error("payload phase with no bytes left");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && result.frame_done) |=> (!in_payload_reg && hdr_idx_reg == '0 &&
                                          idle_reg == 32'd0))
        else $error("frame end did not clear state");

endmodule

>>> src/mfd_queue.sv
// ----------------------------------------------------------------------------
// mfd_queue
// Short result queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module mfd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mfd_pkg::result_t  wdata,
    output logic              full,
    input  logic              pop,
    output logic              rvalid,
    output mfd_pkg::result_t  rdata
);

    mfd_pkg::result_t              slot_reg [mfd_pkg::QDEPTH];
    logic [mfd_pkg::QPTR_W-1:0]    wptr_reg, wptr_next;
    logic [mfd_pkg::QPTR_W-1:0]    rptr_reg, rptr_next;
    logic [mfd_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign full    = (cnt_reg == mfd_pkg::QCNT_W'(mfd_pkg::QDEPTH));
    assign rvalid  = (cnt_reg != '0);
    assign rdata   = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == mfd_pkg::QPTR_W'(mfd_pkg::QDEPTH - 1)) ? '0
                                                                          : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == mfd_pkg::QPTR_W'(mfd_pkg::QDEPTH - 1)) ? '0
                                                                          : rptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

>>> src/mfd_back.sv
// ----------------------------------------------------------------------------
// mfd_back
// Output stage: drains the result queue into the result channel register.
// ----------------------------------------------------------------------------
module mfd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  mfd_pkg::result_t  q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mfd_pkg::result_t  m_data
);

    logic             valid_reg, valid_next;
    mfd_pkg::result_t data_reg;

    assign q_pop   = q_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

endmodule

>>> src/message_frame_deframer.sv
// ----------------------------------------------------------------------------
// message_frame_deframer
// Link event deframer: 12-byte header check, payload pass-through, timeout.
// ----------------------------------------------------------------------------
// Input channel s_*: one link event per request (byte, empty read, link
// down, stop). Result channel m_*: zero or one result per event, in order.
// An event is classified in the cycle it is accepted; its result enters a
// two-entry queue and then reaches the m_ output register. One event per
// cycle is accepted while the queue is not full; the classifier that turns
// each event into a result is combinational (32-bit length and idle compares).
// When the receiver stalls, the output register and queue absorb up to three
// results; s_ready drops only while the queue is full.
// Synchronous reset (aresetn low) clears framing state, queue and output
// valid, and loads the register defaults: magic 0, version 1, capacity 4096,
// idle limit 0 (no timeout). The header store is not cleared.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12; write them
// only while no event is in flight.
// ----------------------------------------------------------------------------
module message_frame_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [7:0]                   s_data_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_status,
    output logic                         m_frame_done,
    output logic [7:0]                   m_msg_type,
    output logic [15:0]                  m_seq_number,
    output logic [15:0]                  m_channel_id,
    output logic [31:0]                  m_payload_length,
    output logic [7:0]                   m_payload_byte,
    output logic                         m_payload_valid
);

    mfd_pkg::cfg_t    cfg_reg, cfg_next;
    mfd_pkg::result_t front_res, q_data, out_data;
    logic             front_push, q_full, q_valid, q_pop;
    logic             in_fire, wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                mfd_pkg::REG_MAGIC:    cfg_next.magic_word       = pwdata[15:0];
                mfd_pkg::REG_VERSION:  cfg_next.wire_version     = pwdata[7:0];
                mfd_pkg::REG_CAPACITY: cfg_next.payload_capacity = pwdata;
                mfd_pkg::REG_IDLE:     cfg_next.idle_limit       = pwdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            mfd_pkg::REG_MAGIC:    prdata = {16'd0, cfg_reg.magic_word};
            mfd_pkg::REG_VERSION:  prdata = {24'd0, cfg_reg.wire_version};
            mfd_pkg::REG_CAPACITY: prdata = cfg_reg.payload_capacity;
            mfd_pkg::REG_IDLE:     prdata = cfg_reg.idle_limit;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word       <= 16'd0;
            cfg_reg.wire_version     <= 8'd1;
            cfg_reg.payload_capacity <= 32'd4096;
            cfg_reg.idle_limit       <= 32'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .action    (s_action),
        .data_byte (s_data_byte),
        .cfg       (cfg_reg),
        .push      (front_push),
        .result    (front_res)
    );

    mfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_push),
        .wdata   (front_res),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_data)
    );

    mfd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (out_data)
    );

    assign m_status         = out_data.status;
    assign m_frame_done     = out_data.frame_done;
    assign m_msg_type       = out_data.msg_type;
    assign m_seq_number     = out_data.seq_number;
    assign m_channel_id     = out_data.channel_id;
    assign m_payload_length = out_data.payload_length;
    assign m_payload_byte   = out_data.payload_byte;
    assign m_payload_valid  = out_data.payload_valid;

endmodule
